>>> rtl/tlvx_pkg.sv
// Shared types and constants for the subrecord tag extractor.
package tlvx_pkg;

    localparam int TagW    = 32;
    localparam int WordW   = 32;
    localparam int CfgIdxW = 2;

    localparam logic [TagW-1:0] TARGET_TAG_RESET      = 32'h434C_4358;
    localparam logic [TagW-1:0] SIZE_PREFIX_TAG_RESET = 32'h5858_5858;

    localparam logic [CfgIdxW-1:0] CFG_TARGET_TAG      = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_PREFIX_TAG = 2'd1;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_SIZE   = 5'b00100,
        PH_TARGET = 5'b01000,
        PH_DRAIN  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [WordW-1:0] coord_x;
        logic signed [WordW-1:0] coord_y;
        logic [WordW-1:0]        cell_flags;
    } result_t;

    typedef struct packed {
        logic [TagW-1:0] target_tag;
        logic [TagW-1:0] size_prefix_tag;
    } tag_cfg_t;

endpackage

>>> rtl/tlvx_in_stage.sv
// Input register stage: holds one byte transfer until the parser takes it.
module tlvx_in_stage
    import tlvx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  byte_item_t s_item,
    input  logic       take_i,
    output logic       valid_o,
    output byte_item_t item_o
);

    logic       valid_reg;
    byte_item_t item_reg;

    assign s_ready = !valid_reg || take_i;
    assign valid_o = valid_reg;
    assign item_o  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

>>> rtl/tlvx_parser.sv
// Subrecord parse state and its per-byte next-state logic.
module tlvx_parser
    import tlvx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance_i,
    input  byte_item_t item_i,
    input  tag_cfg_t   cfg_i,
    output logic       res_valid_o,
    output result_t    res_o
);

    phase_t           phase_reg, phase_next;
    logic [2:0]       header_count_reg, header_count_next;
    logic [TagW-1:0]  tag_shift_reg, tag_shift_next;
    logic [15:0]      length_low_reg, length_low_next;
    logic [31:0]      payload_left_reg, payload_left_next;
    logic [31:0]      pending_big_reg, pending_big_next;
    logic [WordW-1:0] capture_reg [3];
    logic [WordW-1:0] capture_next [3];
    logic [3:0]       payload_taken_reg, payload_taken_next;

    logic [31:0] size;
    phase_t      kind;
    logic        found;
    logic [7:0]  b;

    assign b = item_i.data_byte;

    always_comb begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        tag_shift_next     = tag_shift_reg;
        length_low_next    = length_low_reg;
        payload_left_next  = payload_left_reg;
        pending_big_next   = pending_big_reg;
        capture_next       = capture_reg;
        payload_taken_next = payload_taken_reg;
        size               = pending_big_reg != 32'd0 ? pending_big_reg
                                                      : {16'h0000, b, length_low_reg[7:0]};
        kind               = PH_SKIP;
        found              = 1'b0;
        res_valid_o        = 1'b0;
        res_o              = '0;

        unique case (phase_reg) inside
            PH_DRAIN: begin
            end
            PH_HEADER: begin
                if (header_count_reg < 3'd4) begin
                    tag_shift_next[8*header_count_reg[1:0] +: 8] = b;
                end else if (header_count_reg == 3'd4) begin
                    length_low_next = {8'h00, b};
                end else begin
                    length_low_next[15:8] = b;
                end
                if (header_count_reg == 3'd5) begin
                    // Size-prefix rule wins when both tags match.
                    if (tag_shift_reg == cfg_i.size_prefix_tag) begin
                        if (size == 32'd4) begin
                            kind = PH_SIZE;
                        end
                    end else if (tag_shift_reg == cfg_i.target_tag) begin
                        if (size >= 32'd12) begin
                            kind = PH_TARGET;
                        end
                    end
                    header_count_next  = 3'd0;
                    tag_shift_next     = '0;
                    length_low_next    = '0;
                    pending_big_next   = '0;
                    payload_left_next  = size;
                    payload_taken_next = 4'd0;
                    phase_next         = (size == 32'd0) ? PH_HEADER : kind;
                end else begin
                    header_count_next = header_count_reg + 3'd1;
                end
            end
            PH_SKIP, PH_SIZE, PH_TARGET: begin
                if (payload_taken_reg < 4'd12) begin
                    if (phase_reg == PH_TARGET) begin
                        capture_next[payload_taken_reg[3:2]][8*payload_taken_reg[1:0] +: 8] = b;
                    end else if (phase_reg == PH_SIZE && payload_taken_reg < 4'd4) begin
                        pending_big_next[8*payload_taken_reg[1:0] +: 8] = b;
                    end
                    payload_taken_next = payload_taken_reg + 4'd1;
                end
                payload_left_next = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1) begin
                    if (phase_reg == PH_TARGET) begin
                        found      = 1'b1;
                        phase_next = PH_DRAIN;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        if (found) begin
            res_valid_o      = 1'b1;
            res_o.status     = ST_FOUND;
            res_o.coord_x    = capture_next[0];
            res_o.coord_y    = capture_next[1];
            res_o.cell_flags = capture_next[2];
        end else if (item_i.last_byte && phase_reg != PH_DRAIN) begin
            res_valid_o  = 1'b1;
            res_o.status = (phase_next == PH_HEADER) ? ST_NOTFOUND : ST_TRUNCATED;
        end

        // Buffer end: drop all parse state for the next buffer.
        if (item_i.last_byte) begin
            phase_next         = PH_HEADER;
            header_count_next  = '0;
            tag_shift_next     = '0;
            length_low_next    = '0;
            payload_left_next  = '0;
            pending_big_next   = '0;
            payload_taken_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HEADER;
            header_count_reg  <= '0;
            tag_shift_reg     <= '0;
            length_low_reg    <= '0;
            payload_left_reg  <= '0;
            pending_big_reg   <= '0;
            payload_taken_reg <= '0;
        end else if (advance_i) begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            tag_shift_reg     <= tag_shift_next;
            length_low_reg    <= length_low_next;
            payload_left_reg  <= payload_left_next;
            pending_big_reg   <= pending_big_next;
            payload_taken_reg <= payload_taken_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance_i) begin
            capture_reg <= capture_next;
        end
    end

endmodule

>>> rtl/tlvx_out_stage.sv
// Result register: holds one result until the downstream transfer completes.
module tlvx_out_stage
    import tlvx_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load_i,
    input  result_t res_i,
    output logic    slot_free_o,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res_o
);

    logic    valid_reg;
    result_t res_reg;

    assign slot_free_o = !valid_reg || m_ready;
    assign m_valid     = valid_reg;
    assign res_o       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free_o) begin
            valid_reg <= load_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            res_reg <= res_i;
        end
    end

endmodule

>>> rtl/tlv_subrecord_tag_extractor.sv
// Top level: subrecord tag extractor with config registers and I/O stages.
// A byte waits in the input register; its result, if any, goes to the result register.
// Throughput: one byte per cycle while m_ready is high; the parse recurrence
// (header counter, payload down-counter, tag compares) is combinational logic.
// A full result register with m_ready low stalls the input after one buffered byte.
// Reset: synchronous, active low; clears parse state and stage valids, loads default tags.
module tlv_subrecord_tag_extractor
    import tlvx_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // Byte stream
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_data_byte,
    input  logic                      s_last_byte,
    // Result
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic signed [WordW-1:0]   m_coord_x,
    output logic signed [WordW-1:0]   m_coord_y,
    output logic [WordW-1:0]          m_cell_flags,
    // Configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CfgIdxW-1:0]        cfg_index,
    input  logic [TagW-1:0]           cfg_data
);

    tag_cfg_t   cfg_reg;
    byte_item_t s_item;
    byte_item_t in_item;
    logic       in_valid;
    logic       slot_free;
    logic       advance;
    logic       res_valid;
    result_t    res_comb;
    result_t    res_out;

    // Configuration: always ready; writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_tag      <= TARGET_TAG_RESET;
            cfg_reg.size_prefix_tag <= SIZE_PREFIX_TAG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TARGET_TAG:      cfg_reg.target_tag      <= cfg_data;
                CFG_SIZE_PREFIX_TAG: cfg_reg.size_prefix_tag <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_item.data_byte = s_data_byte;
    assign s_item.last_byte = s_last_byte;

    // Advance the parser whenever a byte is buffered and the result slot can
    // take a new result (or is being drained this cycle).
    assign advance = in_valid && slot_free;

    tlvx_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .take_i  (advance),
        .valid_o (in_valid),
        .item_o  (in_item)
    );

    tlvx_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance_i   (advance),
        .item_i      (in_item),
        .cfg_i       (cfg_reg),
        .res_valid_o (res_valid),
        .res_o       (res_comb)
    );

    // Load a result only on bytes that produce one.
    tlvx_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_i      (advance && res_valid),
        .res_i       (res_comb),
        .slot_free_o (slot_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .res_o       (res_out)
    );

    assign m_status     = res_out.status;
    assign m_coord_x    = res_out.coord_x;
    assign m_coord_y    = res_out.coord_y;
    assign m_cell_flags = res_out.cell_flags;

`ifndef SYNTH
    // Words are only carried on a found result.
    a_words_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_FOUND |->
            m_coord_x == '0 && m_coord_y == '0 && m_cell_flags == '0)
        else $error("result words nonzero on a non-found status");

    // Status is one of the three defined codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_FOUND || m_status == ST_NOTFOUND ||
                     m_status == ST_TRUNCATED))
        else $error("undefined status code");

    // The input only stalls behind a held result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without downstream backpressure");
`endif

endmodule
